// ----- src/lidar_point_grid_binning_top_defines.svh -----
// Assertion macros for the lidar point grid binning block.
// Used by the port-level checker; expects clk and rst_n in the scope of use.
`ifndef LIDAR_POINT_GRID_BINNING_TOP_DEFINES_SVH
`define LIDAR_POINT_GRID_BINNING_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define LPGB_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lpgb: same-cycle check failed");

// Next-cycle implication, disabled while reset is held.
`define LPGB_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lpgb: next-cycle check failed");

`endif

// ----- src/lpgb_pkg.sv -----
// Shared types and constants of the lidar point grid binning block.
// No dependencies; imported by the top level and its checker.
package lpgb_pkg;

  localparam int X_W         = 20;
  localparam int Z_W         = 32;
  localparam int CLASS_W     = 8;
  localparam int CELL_W      = 9;
  localparam int CFG_W       = 10;
  localparam int CFG_IDX_W   = 1;
  localparam int DIM_W       = 11;
  localparam int COORD_W     = 13;
  localparam int DIST_W      = 20;
  localparam int IN_TDATA_W  = 104;
  localparam int IN_TUSER_W  = 1;
  localparam int OUT_TDATA_W = 72;

  localparam int OUT_SURF_VALID_BIT = 32;
  localparam int OUT_GND_VALID_BIT  = 65;

  localparam int EDGE_MARGIN = 3;

  localparam logic [CFG_W-1:0]   CFG_DIM_RESET    = 10'd512;
  localparam logic [DIST_W-1:0]  DIST_RESET       = 20'd589824;
  localparam logic [CLASS_W-1:0] CLASS_GROUND     = 8'd2;
  localparam logic [CLASS_W-1:0] CLASS_NOISE_LOW  = 8'd7;
  localparam logic [CLASS_W-1:0] CLASS_NOISE_HIGH = 8'd18;

  typedef enum logic {
    OP_ADD  = 1'b0,
    OP_READ = 1'b1
  } opcode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GRID_WIDTH  = 1'b0,
    REG_GRID_HEIGHT = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic [Z_W-1:0]    surf_h;
    logic              seen;
    logic [Z_W-1:0]    gnd_h;
    logic [DIST_W-1:0] gnd_d;
  } cell_word_t;

  localparam cell_word_t CELL_RESET = '{
    surf_h: '0,
    seen:   1'b0,
    gnd_h:  '0,
    gnd_d:  DIST_RESET
  };

endpackage

// ----- src/lidar_point_grid_binning_top.sv -----
// Lidar point grid binning: top level with the cell memory and its sequencer.
// Depends on lpgb_pkg.
//
// Channel   Dir  Handshake                 Payload
// in_*      in   in_tvalid / in_tready     in_tdata (point or cell address), in_tuser (opcode)
// out_*     out  out_tvalid / out_tready   out_tdata (one cell's stored values)
// cfg_*     in   cfg_we                    cfg_index, cfg_wdata (grid size)
//
// After reset a clearing pass writes all GRID_DIM*GRID_DIM cells (262144 at the default
// size), with in_tready low; configuration writes are taken meanwhile.
// An add beat visits N cells before in_tready rises again, N being one for a plain
// point and up to (2*GROUND_RADIUS+1)^2 (49) for a ground point, since every cell goes
// through the one read port and the one write port of the cell memory in turn.
// Points that visit no cell go back to idle straight from setup.
// A read waits in place while the output register still holds an untaken result;
// no new beat is accepted meanwhile.
module lidar_point_grid_binning_top #(
  parameter int GRID_DIM      = 512,
  parameter int GROUND_RADIUS = 3
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // in_tdata, from bit 0: x_pos[19:0], y_pos[39:20], z_mm[71:40], point_class[79:72],
  // withheld[80], cell_col[89:81], cell_row[98:90], zero pad [103:99]
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [lpgb_pkg::IN_TDATA_W-1:0]  in_tdata,
  // in_tuser, from bit 0: opcode[0]
  input  logic [lpgb_pkg::IN_TUSER_W-1:0]  in_tuser,
  // out_tdata, from bit 0: surface_z[31:0], surface_valid[32], ground_z[64:33],
  // ground_valid[65], zero pad [71:66]
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [lpgb_pkg::OUT_TDATA_W-1:0] out_tdata,
  input  logic                             cfg_we,
  input  logic [lpgb_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [lpgb_pkg::CFG_W-1:0]       cfg_wdata
);
  import lpgb_pkg::*;

  localparam int CELLS  = GRID_DIM * GRID_DIM;
  localparam int ADDR_W = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int IDX_W  = (GRID_DIM > 1) ? $clog2(GRID_DIM) : 1;
  // |dx| stays below (GROUND_RADIUS+1) m in Q8 inside the visit window
  localparam int DX_W   = $clog2((GROUND_RADIUS + 1) * 256) + 1;
  localparam int SQ_W   = 2 * DX_W;
  localparam int DSQ_W  = SQ_W + 1;
  localparam int OFS_W  = X_W + 2;

  localparam logic [ADDR_W-1:0]         CLR_LAST  = ADDR_W'(CELLS - 1);
  localparam logic [ADDR_W-1:0]         ROW_STEP  = ADDR_W'(GRID_DIM);
  localparam logic [DIM_W-1:0]          DIM_MAX   = DIM_W'(GRID_DIM);
  localparam logic signed [COORD_W-1:0] RAD       = COORD_W'(GROUND_RADIUS);
  localparam logic signed [OFS_W-1:0]   MARGIN_LO = OFS_W'(-EDGE_MARGIN * 256);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SETUP,
    S_SWEEP,
    S_DRAIN,
    S_RD_WAIT
  } state_t;

  state_t state_r, state_nxt;

  // configuration
  logic [CFG_W-1:0] cfg_width_r, cfg_height_r;
  logic [DIM_W-1:0] w_eff, h_eff;

  // latched input beat
  opcode_t                    op_r;
  logic signed [X_W-1:0]      x_r, y_r;
  logic signed [Z_W-1:0]      z_r;
  logic [CLASS_W-1:0]         cls_r;
  logic                       withheld_r;
  logic [CELL_W-1:0]          cell_col_r, cell_row_r;

  // sweep control
  logic [IDX_W-1:0]  c_r, c_nxt, r_r, r_nxt;
  logic [IDX_W-1:0]  clo_r, clo_nxt, chi_r, chi_nxt, rhi_r, rhi_nxt;
  logic [IDX_W-1:0]  own_c_r, own_c_nxt, own_r_r, own_r_nxt;
  logic [ADDR_W-1:0] row_base_r, row_base_nxt;
  logic              own_in_r, own_in_nxt, ground_r, ground_nxt;

  // write-back stage
  logic              p_valid_r, p_valid_nxt;
  logic [ADDR_W-1:0] p_addr_r, p_addr_nxt;
  logic              p_own_r, p_own_nxt;
  logic [SQ_W-1:0]   p_sqx_r, p_sqx_nxt, p_sqy_r, p_sqy_nxt;

  logic                   rd_oor_r, rd_oor_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [OUT_TDATA_W-1:0] out_data_r, out_data_nxt;
  logic [ADDR_W-1:0]      clr_addr_r, clr_addr_nxt;

  // cell memory
  cell_word_t        mem [0:CELLS-1];
  cell_word_t        rdata_r;
  logic              mem_re, mem_we;
  logic [ADDR_W-1:0] mem_raddr, mem_waddr;
  cell_word_t        mem_wdata;

  // setup-cycle signals
  logic                       in_fire;
  logic signed [COORD_W-1:0]  w_s, h_s, col_s, row_s;
  logic signed [COORD_W-1:0]  clo_s, chi_s, rlo_s, rhi_s;
  logic [IDX_W-1:0]           clo_u, chi_u, rlo_u, rhi_u, col_u, row_u;
  logic signed [OFS_W-1:0]    x_ext, y_ext, lim_x, lim_y;
  logic                       drop, own_in, is_ground, empty, go;
  logic                       rd_oor;
  logic [ADDR_W-1:0]          rd_addr;

  // sweep issue and write-back signals
  logic [ADDR_W-1:0]          cur_addr;
  logic signed [OFS_W-1:0]    dx_full, dy_full;
  logic signed [DX_W-1:0]     dx, dy;
  logic signed [SQ_W-1:0]     sqx, sqy;
  logic [DSQ_W-1:0]           dist_sq;
  cell_word_t                 word_new;

  assign in_fire    = in_tvalid && in_tready;
  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // Sizes above GRID_DIM act as GRID_DIM.
  assign w_eff = (DIM_W'(cfg_width_r) > DIM_MAX) ? DIM_MAX : DIM_W'(cfg_width_r);
  assign h_eff = (DIM_W'(cfg_height_r) > DIM_MAX) ? DIM_MAX : DIM_W'(cfg_height_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_width_r  <= CFG_DIM_RESET;
      cfg_height_r <= CFG_DIM_RESET;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_GRID_WIDTH:  cfg_width_r  <= cfg_wdata;
        REG_GRID_HEIGHT: cfg_height_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Hold the accepted beat for the whole operation.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_r       <= opcode_t'(in_tuser[0]);
      x_r        <= in_tdata[19:0];
      y_r        <= in_tdata[39:20];
      z_r        <= in_tdata[71:40];
      cls_r      <= in_tdata[79:72];
      withheld_r <= in_tdata[80];
      cell_col_r <= in_tdata[89:81];
      cell_row_r <= in_tdata[98:90];
    end
  end

  // Setup: filter the point and clip its visit window to the grid in use.
  always_comb begin
    w_s   = COORD_W'(w_eff);
    h_s   = COORD_W'(h_eff);
    col_s = COORD_W'(x_r >>> 8);
    row_s = COORD_W'(y_r >>> 8);
    x_ext = OFS_W'(x_r);
    y_ext = OFS_W'(y_r);
    lim_x = OFS_W'({w_eff + DIM_W'(EDGE_MARGIN), 8'h00});
    lim_y = OFS_W'({h_eff + DIM_W'(EDGE_MARGIN), 8'h00});

    drop = withheld_r || (cls_r == CLASS_NOISE_LOW) || (cls_r == CLASS_NOISE_HIGH) ||
           (x_ext < MARGIN_LO) || (y_ext < MARGIN_LO) ||
           (x_ext > lim_x) || (y_ext > lim_y);
    own_in    = (col_s >= 0) && (row_s >= 0) && (col_s < w_s) && (row_s < h_s);
    is_ground = (cls_r == CLASS_GROUND);

    if (is_ground) begin
      clo_s = (col_s - RAD < 0) ? '0 : col_s - RAD;
      chi_s = (col_s + RAD > w_s - COORD_W'(1)) ? w_s - COORD_W'(1) : col_s + RAD;
      rlo_s = (row_s - RAD < 0) ? '0 : row_s - RAD;
      rhi_s = (row_s + RAD > h_s - COORD_W'(1)) ? h_s - COORD_W'(1) : row_s + RAD;
      empty = (clo_s > chi_s) || (rlo_s > rhi_s);
    end else begin
      // a plain point only visits its own cell
      clo_s = col_s;
      chi_s = col_s;
      rlo_s = row_s;
      rhi_s = row_s;
      empty = !own_in;
    end
    go = !drop && !empty;

    clo_u = IDX_W'(clo_s);
    chi_u = IDX_W'(chi_s);
    rlo_u = IDX_W'(rlo_s);
    rhi_u = IDX_W'(rhi_s);
    col_u = IDX_W'(col_s);
    row_u = IDX_W'(row_s);

    rd_oor  = (DIM_W'(cell_col_r) >= w_eff) || (DIM_W'(cell_row_r) >= h_eff);
    rd_addr = ADDR_W'(cell_row_r) * ROW_STEP + ADDR_W'(cell_col_r);
  end

  // Sweep issue: address and squared offsets of the cell being read.
  always_comb begin
    cur_addr = row_base_r + ADDR_W'(c_r);
    dx_full  = OFS_W'(x_r) - OFS_W'({c_r, 8'h80});
    dy_full  = OFS_W'(y_r) - OFS_W'({r_r, 8'h80});
    dx       = dx_full[DX_W-1:0];
    dy       = dy_full[DX_W-1:0];
    sqx      = SQ_W'(dx) * SQ_W'(dx);
    sqy      = SQ_W'(dy) * SQ_W'(dy);
  end

  // Write-back: merge the point into the word read in the previous cycle.
  always_comb begin
    dist_sq  = DSQ_W'(p_sqx_r) + DSQ_W'(p_sqy_r);
    word_new = rdata_r;
    if (p_own_r && (!rdata_r.seen || (z_r > $signed(rdata_r.surf_h)))) begin
      word_new.surf_h = z_r;
      word_new.seen   = 1'b1;
    end
    if (ground_r && (dist_sq < DSQ_W'(rdata_r.gnd_d))) begin
      word_new.gnd_d = DIST_W'(dist_sq);
      word_new.gnd_h = z_r;
    end
  end

  // Memory ports: the clearing pass owns the write port until it ends.
  always_comb begin
    mem_we    = (state_r == S_CLEAR) || p_valid_r;
    mem_waddr = (state_r == S_CLEAR) ? clr_addr_r : p_addr_r;
    mem_wdata = (state_r == S_CLEAR) ? CELL_RESET : word_new;
    mem_re    = (state_r == S_SWEEP) ||
                ((state_r == S_SETUP) && (op_r == OP_READ) && !rd_oor);
    mem_raddr = (state_r == S_SWEEP) ? cur_addr : rd_addr;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_r <= mem[mem_raddr];
    end
  end

  // Sequencer next state.
  always_comb begin
    state_nxt    = state_r;
    clr_addr_nxt = clr_addr_r;
    c_nxt        = c_r;
    r_nxt        = r_r;
    clo_nxt      = clo_r;
    chi_nxt      = chi_r;
    rhi_nxt      = rhi_r;
    own_c_nxt    = own_c_r;
    own_r_nxt    = own_r_r;
    row_base_nxt = row_base_r;
    own_in_nxt   = own_in_r;
    ground_nxt   = ground_r;
    p_valid_nxt  = 1'b0;
    p_addr_nxt   = cur_addr;
    p_own_nxt    = own_in_r && (c_r == own_c_r) && (r_r == own_r_r);
    p_sqx_nxt    = sqx;
    p_sqy_nxt    = sqy;
    rd_oor_nxt   = rd_oor_r;
    out_data_nxt = out_data_r;
    out_valid_nxt = out_valid_r && !out_tready;

    case (state_r)
      S_CLEAR: begin
        clr_addr_nxt = clr_addr_r + ADDR_W'(1);
        if (clr_addr_r == CLR_LAST) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_fire) begin
          state_nxt = S_SETUP;
        end
      end
      S_SETUP: begin
        if (op_r == OP_READ) begin
          rd_oor_nxt = rd_oor;
          state_nxt  = S_RD_WAIT;
        end else if (go) begin
          c_nxt        = clo_u;
          r_nxt        = rlo_u;
          clo_nxt      = clo_u;
          chi_nxt      = chi_u;
          rhi_nxt      = rhi_u;
          own_c_nxt    = col_u;
          own_r_nxt    = row_u;
          own_in_nxt   = own_in;
          ground_nxt   = is_ground;
          row_base_nxt = ADDR_W'(rlo_u) * ROW_STEP;
          state_nxt    = S_SWEEP;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_SWEEP: begin
        // issue one cell a cycle, row by row
        p_valid_nxt = 1'b1;
        if (c_r == chi_r) begin
          c_nxt = clo_r;
          if (r_r == rhi_r) begin
            state_nxt = S_DRAIN;
          end else begin
            r_nxt        = r_r + IDX_W'(1);
            row_base_nxt = row_base_r + ROW_STEP;
          end
        end else begin
          c_nxt = c_r + IDX_W'(1);
        end
      end
      S_DRAIN: begin
        state_nxt = S_IDLE;
      end
      S_RD_WAIT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          if (rd_oor_r) begin
            out_data_nxt = '0;
          end else begin
            out_data_nxt = {6'b0, (rdata_r.gnd_d < DIST_RESET), rdata_r.gnd_h,
                            rdata_r.seen, rdata_r.surf_h};
          end
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    c_r        <= c_nxt;
    r_r        <= r_nxt;
    clo_r      <= clo_nxt;
    chi_r      <= chi_nxt;
    rhi_r      <= rhi_nxt;
    own_c_r    <= own_c_nxt;
    own_r_r    <= own_r_nxt;
    row_base_r <= row_base_nxt;
    own_in_r   <= own_in_nxt;
    ground_r   <= ground_nxt;
    p_addr_r   <= p_addr_nxt;
    p_own_r    <= p_own_nxt;
    p_sqx_r    <= p_sqx_nxt;
    p_sqy_r    <= p_sqy_nxt;
    rd_oor_r   <= rd_oor_nxt;
    out_data_r <= out_data_nxt;
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_addr_r  <= '0;
      p_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      p_valid_r   <= p_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ----- src/lpgb_checker.sv -----
// Port-level checker for the lidar point grid binning block, bound to the top level.
// Depends on lpgb_pkg and lidar_point_grid_binning_top_defines.svh.
`include "lidar_point_grid_binning_top_defines.svh"

module lpgb_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [lpgb_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import lpgb_pkg::*;

  logic surf_empty, gnd_empty;

  assign surf_empty = out_tvalid && !out_tdata[OUT_SURF_VALID_BIT];
  assign gnd_empty  = out_tvalid && !out_tdata[OUT_GND_VALID_BIT];

  // stalled result beat holds
  `LPGB_ASSERT_NXT(a_out_hold, out_tvalid && !out_tready, out_tvalid)
  `LPGB_ASSERT_NXT(a_out_stable, out_tvalid && !out_tready, $stable(out_tdata))

  // every accepted beat keeps the sequencer busy for at least the setup cycle
  `LPGB_ASSERT_NXT(a_busy_after_accept, in_tvalid && in_tready, !in_tready)

  // a cell that never took a value reports zero heights
  `LPGB_ASSERT_IMP(a_surface_empty_zero, surf_empty, out_tdata[31:0] == 32'd0)
  `LPGB_ASSERT_IMP(a_ground_empty_zero, gnd_empty, out_tdata[64:33] == 32'd0)

endmodule

bind lidar_point_grid_binning_top lpgb_checker u_lpgb_checker (.*);
